// ----- sv/ipq_pkg.sv -----
// package for the indexed priority task queue
// shared widths, request and status codes and the entry and payload structs
// no dependencies
`default_nettype none

package ipq_pkg;

  localparam int unsigned TID_W  = 20;
  localparam int unsigned UID_W  = 20;
  localparam int unsigned PRIO_W = 32;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EDIT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_EXEC   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // one table entry as stored in the memory
  typedef struct packed {
    logic              vld;
    logic [TID_W-1:0]  tid;
    logic [UID_W-1:0]  uid;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // latched request
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TID_W-1:0]  tid;
    logic [UID_W-1:0]  uid;
    logic [PRIO_W-1:0] prio;
  } req_t;

  // outcome of comparing one entry against the request and the running best
  typedef struct packed {
    logic match;
    logic empty;
    logic better;
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- sv/ipq_req_if.sv -----
// request channel of the indexed priority task queue
// depends on ipq_pkg
`default_nettype none

interface ipq_req_if;
  logic                        valid;
  logic                        ready;
  logic [ipq_pkg::REQ_W-1:0]   req_type;
  logic [ipq_pkg::TID_W-1:0]   task_id;
  logic [ipq_pkg::UID_W-1:0]   user_id;
  logic [ipq_pkg::PRIO_W-1:0]  priority_req;

  modport source (output valid, req_type, task_id, user_id, priority_req, input ready);
  modport sink (input valid, req_type, task_id, user_id, priority_req, output ready);
endinterface

`default_nettype wire

// ----- sv/ipq_rsp_if.sv -----
// response channel of the indexed priority task queue
// depends on ipq_pkg
`default_nettype none

interface ipq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ipq_pkg::STAT_W-1:0]  status;
  logic [ipq_pkg::UID_W-1:0]   owner_id;

  modport source (output valid, status, owner_id, input ready);
  modport sink (input valid, status, owner_id, output ready);
endinterface

`default_nettype wire

// ----- sv/indexed_priority_task_queue_core.sv -----
// top level of the indexed priority task queue: scan sequencer and result register
// depends on ipq_pkg, ipq_req_if, ipq_rsp_if, ipq_mem, ipq_cmp
//
//   port    dir  modport  payload
//   req_i   in   sink     req_type, task_id, user_id, priority_req
//   rsp_o   out  source   status, owner_id
//
// after acceptance each request scans the whole table before its result is loaded:
// one memory read and one shared compare per entry, then the eval and commit states
// after reset a clearing pass marks every entry free;
// req_i.ready stays low until it ends
// a new request is taken while a finished result still waits on rsp_o;
// a stalled rsp_o holds the next result back before it is loaded
`default_nettype none

module indexed_priority_task_queue_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ipq_req_if.sink    req_i,
  ipq_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q;

  ipq_pkg::req_t req_q;

  logic match_q, match_d;
  logic [IDX_W-1:0] match_idx_q;
  logic [ipq_pkg::UID_W-1:0] match_uid_q;
  logic free_q, free_d;
  logic [IDX_W-1:0] free_idx_q;
  logic best_q, best_d;
  logic [IDX_W-1:0] best_idx_q;
  logic [ipq_pkg::PRIO_W-1:0] best_prio_q;
  logic [ipq_pkg::TID_W-1:0] best_tid_q;
  logic [ipq_pkg::UID_W-1:0] best_uid_q;

  logic [ipq_pkg::STAT_W-1:0] res_status_q, res_status_d;
  logic [ipq_pkg::UID_W-1:0] res_owner_q, res_owner_d;

  logic rsp_vld_q;
  logic [ipq_pkg::STAT_W-1:0] rsp_status_q;
  logic [ipq_pkg::UID_W-1:0] rsp_owner_q;

  logic req_acc;
  logic rsp_load;
  logic eval_en;
  logic take_match, take_free, take_best;

  logic mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ipq_pkg::entry_t mem_wdata;
  ipq_pkg::entry_t mem_rdata;
  ipq_pkg::cmp_res_t cmp_res;

  // table memory, read address follows the scan index
  ipq_mem #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // one compare per scanned entry
  ipq_cmp u_cmp (
    .entry_i     (mem_rdata),
    .tid_i       (req_q.tid),
    .best_vld_i  (best_q),
    .best_prio_i (best_prio_q),
    .best_tid_i  (best_tid_q),
    .res_o       (cmp_res)
  );

  // handshakes
  assign req_i.ready   = (state_q == S_IDLE);
  assign req_acc       = req_i.valid && req_i.ready;
  assign rsp_load      = (state_q == S_RESP) && (!rsp_vld_q || rsp_o.ready);
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.status  = rsp_status_q;
  assign rsp_o.owner_id = rsp_owner_q;

  // scan bookkeeping for the entry whose read data is present
  assign eval_en    = pend_q;
  assign take_match = eval_en && cmp_res.match && !match_q;
  assign take_free  = eval_en && cmp_res.empty && !free_q;
  assign take_best  = eval_en && cmp_res.better;

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    match_d = match_q || take_match;
    free_d  = free_q || take_free;
    best_d  = best_q || take_best;
    unique case (state_q)
      S_CLR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          idx_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
          best_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        pend_d = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_EVAL;
        end
      end
      S_EVAL:   state_d = S_COMMIT;
      S_COMMIT: state_d = S_RESP;
      S_RESP: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // table clear after reset, and table update and result at the end of the scan
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = '0;
    res_status_d = res_status_q;
    res_owner_d  = res_owner_q;
    if (state_q == S_CLR) begin
      mem_we = 1'b1;
    end else if (state_q == S_COMMIT) begin
      res_status_d = ipq_pkg::ST_DONE;
      res_owner_d  = '0;
      unique case (req_q.req_type)
        ipq_pkg::REQ_ADD: begin
          mem_wdata = '{vld: 1'b1, tid: req_q.tid, uid: req_q.uid, prio: req_q.prio};
          if (match_q) begin
            mem_we    = 1'b1;
            mem_waddr = match_idx_q;
          end else if (free_q) begin
            mem_we    = 1'b1;
            mem_waddr = free_idx_q;
          end else begin
            res_status_d = ipq_pkg::ST_FULL;
          end
        end
        ipq_pkg::REQ_EDIT: begin
          mem_wdata = '{vld: 1'b1, tid: req_q.tid, uid: match_uid_q, prio: req_q.prio};
          mem_waddr = match_idx_q;
          mem_we    = match_q;
          if (!match_q) begin
            res_status_d = ipq_pkg::ST_MISS;
          end
        end
        ipq_pkg::REQ_REMOVE: begin
          mem_waddr = match_idx_q;
          mem_we    = match_q;
          if (!match_q) begin
            res_status_d = ipq_pkg::ST_MISS;
          end
        end
        ipq_pkg::REQ_EXEC: begin
          mem_waddr = best_idx_q;
          mem_we    = best_q;
          if (best_q) begin
            res_owner_d = best_uid_q;
          end else begin
            res_status_d = ipq_pkg::ST_MISS;
          end
        end
        default: res_status_d = ipq_pkg::ST_MISS;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      best_q    <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      match_q <= match_d;
      free_q  <= free_d;
      best_q  <= best_d;
      if (rsp_load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q   <= idx_q;
    res_status_q <= res_status_d;
    res_owner_q  <= res_owner_d;
    if (req_acc) begin
      req_q <= '{req_type: req_i.req_type, tid: req_i.task_id,
                 uid: req_i.user_id, prio: req_i.priority_req};
    end
    if (take_match) begin
      match_idx_q <= pend_idx_q;
      match_uid_q <= mem_rdata.uid;
    end
    if (take_free) begin
      free_idx_q <= pend_idx_q;
    end
    if (take_best) begin
      best_idx_q  <= pend_idx_q;
      best_prio_q <= mem_rdata.prio;
      best_tid_q  <= mem_rdata.tid;
      best_uid_q  <= mem_rdata.uid;
    end
    if (rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_owner_q  <= res_owner_q;
    end
  end

  // checks
  a_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLR || state_q == S_COMMIT))
    else $error("table written outside clear or commit");

  a_acc_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == S_SCAN && idx_q == '0))
    else $error("accepted request did not start a scan at entry zero");

  a_pend_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN || state_q == S_EVAL))
    else $error("entry evaluated outside the scan");

  a_owner_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && rsp_status_q != ipq_pkg::ST_DONE) |-> (rsp_owner_q == '0))
    else $error("refused request carries an owner");

  a_rsp_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |=> rsp_vld_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- sv/ipq_mem.sv -----
// task table memory: one write port, one read port with registered read data
// depends on ipq_pkg for the entry type
`default_nettype none

module ipq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire ipq_pkg::entry_t      wdata_i,
  input  wire logic [AW-1:0]        raddr_i,
  output ipq_pkg::entry_t           rdata_o
);

  ipq_pkg::entry_t mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/ipq_cmp.sv -----
// shared compare unit: checks one entry for id match, free slot and new best
// depends on ipq_pkg
`default_nettype none

module ipq_cmp (
  input  wire ipq_pkg::entry_t            entry_i,
  input  wire logic [ipq_pkg::TID_W-1:0]  tid_i,
  input  wire logic                       best_vld_i,
  input  wire logic [ipq_pkg::PRIO_W-1:0] best_prio_i,
  input  wire logic [ipq_pkg::TID_W-1:0]  best_tid_i,
  output ipq_pkg::cmp_res_t               res_o
);

  logic prio_gt;
  logic prio_eq;
  logic tid_gt;

  // priority order with ties to the higher id
  assign prio_gt = entry_i.prio > best_prio_i;
  assign prio_eq = entry_i.prio == best_prio_i;
  assign tid_gt  = entry_i.tid > best_tid_i;

  assign res_o.match  = entry_i.vld && (entry_i.tid == tid_i);
  assign res_o.empty  = !entry_i.vld;
  assign res_o.better = entry_i.vld && (!best_vld_i || prio_gt || (prio_eq && tid_gt));

endmodule

`default_nettype wire

// ----- tb/indexed_priority_task_queue_core_tb.sv -----
// self-checking testbench for indexed_priority_task_queue_core
// predicts each response from its own copy of the task table and checks it field by field
// depends on ipq_pkg, ipq_req_if, ipq_rsp_if and the core
module indexed_priority_task_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS      = 64;
  localparam int          N_RANDOM   = 1900;
  localparam int          HOLD_AT    = 1200;
  localparam int          HOLD_LEN   = 600;
  localparam int          CALM_FROM  = 40000;
  localparam int          CALM_TO    = 56000;
  localparam int          IDLE_PCT   = 17;
  localparam int          POOL_MAX   = 160;

  localparam int unsigned TID_W  = ipq_pkg::TID_W;
  localparam int unsigned UID_W  = ipq_pkg::UID_W;
  localparam int unsigned PRIO_W = ipq_pkg::PRIO_W;
  localparam int unsigned REQ_W  = ipq_pkg::REQ_W;
  localparam int unsigned STAT_W = ipq_pkg::STAT_W;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [UID_W-1:0]  owner;
  } outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ipq_req_if req_if ();
  ipq_rsp_if rsp_if ();

  indexed_priority_task_queue_core #(
    .CAPACITY (SLOTS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow task table
  bit                slot_used [SLOTS];
  logic [TID_W-1:0]  slot_tid  [SLOTS];
  logic [UID_W-1:0]  slot_uid  [SLOTS];
  logic [PRIO_W-1:0] slot_prio [SLOTS];

  ipq_pkg::req_t req_backlog [$];
  outcome_t      owed_outcomes [$];
  ipq_pkg::req_t offered;
  ipq_pkg::req_t next_req;
  outcome_t      want;
  int       errors = 0;
  int       n_sent = 0;
  int       cyc = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  logic     calm;

  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) cyc <= cyc + 1;

  // apply one request to the shadow table and return the response it should give
  function automatic outcome_t table_update(ipq_pkg::req_t r);
    int       hit;
    int       free_idx;
    int       top;
    outcome_t o;
    hit      = -1;
    free_idx = -1;
    top      = -1;
    o.status = ipq_pkg::ST_DONE;
    o.owner  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_tid[i] == r.tid && hit < 0) hit = i;
      if (!slot_used[i] && free_idx < 0) free_idx = i;
      if (slot_used[i] && (top < 0 || slot_prio[i] > slot_prio[top] ||
          (slot_prio[i] == slot_prio[top] && slot_tid[i] > slot_tid[top]))) top = i;
    end
    case (r.req_type)
      ipq_pkg::REQ_ADD: begin
        if (hit >= 0) begin
          slot_uid[hit]  = r.uid;
          slot_prio[hit] = r.prio;
        end else if (free_idx < 0) begin
          o.status = ipq_pkg::ST_FULL;
        end else begin
          slot_used[free_idx] = 1'b1;
          slot_tid[free_idx]  = r.tid;
          slot_uid[free_idx]  = r.uid;
          slot_prio[free_idx] = r.prio;
        end
      end
      ipq_pkg::REQ_EDIT: begin
        if (hit < 0) o.status = ipq_pkg::ST_MISS;
        else slot_prio[hit] = r.prio;
      end
      ipq_pkg::REQ_REMOVE: begin
        if (hit < 0) o.status = ipq_pkg::ST_MISS;
        else slot_used[hit] = 1'b0;
      end
      default: begin
        if (top < 0) begin
          o.status = ipq_pkg::ST_MISS;
        end else begin
          o.owner        = slot_uid[top];
          slot_used[top] = 1'b0;
        end
      end
    endcase
    return o;
  endfunction

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [TID_W-1:0] id,
                           input logic [UID_W-1:0] uid, input logic [PRIO_W-1:0] prio);
    ipq_pkg::req_t r;
    r.req_type = kind;
    r.tid      = id;
    r.uid      = uid;
    r.prio     = prio;
    req_backlog.push_back(r);
  endtask

  // priorities lean toward extremes and a small set so ties happen often
  function automatic logic [PRIO_W-1:0] pick_prio();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 40) return PRIO_W'($urandom_range(3));
    return PRIO_W'($urandom);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid && req_if.ready) begin
        owed_outcomes.push_back(table_update(offered));
        n_sent <= n_sent + 1;
      end
      if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_req = req_backlog.pop_front();
        offered  = next_req;
        req_if.valid        <= 1'b1;
        req_if.req_type     <= next_req.req_type;
        req_if.task_id      <= next_req.tid;
        req_if.user_id      <= next_req.uid;
        req_if.priority_req <= next_req.prio;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response ready, with one long hold-off to back the core up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_LEN;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (owed_outcomes.size() == 0) begin
        $display("%0t: unexpected response status %0d owner %05h", $time,
                 rsp_if.status, rsp_if.owner_id);
        errors++;
      end else begin
        want = owed_outcomes.pop_front();
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.owner_id !== want.owner) begin
          $display("%0t: owner_id expected %05h actual %05h", $time, want.owner,
                   rsp_if.owner_id);
          errors++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [TID_W-1:0]  id_pool [$];
    logic [TID_W-1:0]  id;
    logic [REQ_W-1:0]  kind;
    int                mode;
    int                roll;
    int                add_cut;
    int                edit_cut;
    int                rem_cut;

    req_if.valid        = 1'b0;
    req_if.req_type     = ipq_pkg::REQ_ADD;
    req_if.task_id      = '0;
    req_if.user_id      = '0;
    req_if.priority_req = '0;
    rsp_if.ready        = 1'b0;

    // directed: empty table, unknown ids, extremes, replace, ties
    queue_req(ipq_pkg::REQ_EXEC,   '1,         '1,         '1);
    queue_req(ipq_pkg::REQ_EDIT,   20'h12345,  '1,         32'h5);
    queue_req(ipq_pkg::REQ_REMOVE, '0,         '1,         '1);
    queue_req(ipq_pkg::REQ_ADD,    '0,         '0,         '0);
    queue_req(ipq_pkg::REQ_ADD,    '1,         '1,         '1);
    queue_req(ipq_pkg::REQ_ADD,    20'h5,      20'hABCDE,  '1);
    queue_req(ipq_pkg::REQ_ADD,    20'h7,      20'h11111,  32'd100);
    queue_req(ipq_pkg::REQ_ADD,    20'h7,      20'h22222,  32'd200);
    queue_req(ipq_pkg::REQ_EDIT,   '0,         20'h33333,  32'd200);
    queue_req(ipq_pkg::REQ_EDIT,   20'h5,      '1,         '0);
    queue_req(ipq_pkg::REQ_EXEC,   20'h5,      20'h44444,  '0);
    queue_req(ipq_pkg::REQ_EXEC,   '0,         '0,         '1);
    queue_req(ipq_pkg::REQ_EXEC,   '1,         '1,         '0);
    queue_req(ipq_pkg::REQ_REMOVE, 20'h5,      20'h12345,  '1);
    queue_req(ipq_pkg::REQ_REMOVE, 20'h5,      '0,         '0);
    queue_req(ipq_pkg::REQ_EXEC,   '0,         '0,         '0);
    queue_req(ipq_pkg::REQ_ADD,    20'h3,      20'h55555,  '0);
    queue_req(ipq_pkg::REQ_ADD,    20'h9,      20'h66666,  '0);
    queue_req(ipq_pkg::REQ_EXEC,   '0,         '0,         '0);
    queue_req(ipq_pkg::REQ_EXEC,   '0,         '0,         '0);
    queue_req(ipq_pkg::REQ_EXEC,   '0,         '0,         '0);

    // random: fill, mixed and drain phases in turn so the table reaches full and empty
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = (n / 120) % 3;
      case (mode)
        0:       begin add_cut = 85; edit_cut = 90; rem_cut = 93; end
        1:       begin add_cut = 35; edit_cut = 55; rem_cut = 75; end
        default: begin add_cut = 10; edit_cut = 20; rem_cut = 35; end
      endcase
      roll = $urandom_range(99);
      if (roll < add_cut) kind = ipq_pkg::REQ_ADD;
      else if (roll < edit_cut) kind = ipq_pkg::REQ_EDIT;
      else if (roll < rem_cut) kind = ipq_pkg::REQ_REMOVE;
      else kind = ipq_pkg::REQ_EXEC;

      roll = $urandom_range(99);
      if (id_pool.size() != 0 &&
          ((kind == ipq_pkg::REQ_ADD && roll < 30) ||
           (kind != ipq_pkg::REQ_ADD && roll < 80))) begin
        id = id_pool[$urandom_range(id_pool.size() - 1)];
      end else begin
        id = TID_W'($urandom);
        if (kind == ipq_pkg::REQ_ADD) begin
          id_pool.push_back(id);
          if (id_pool.size() > POOL_MAX) void'(id_pool.pop_front());
        end
      end
      queue_req(kind, id, UID_W'($urandom), pick_prio());
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (req_backlog.size() == 0);
    @(posedge clk_i);
    while (req_if.valid || owed_outcomes.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 40) @(posedge clk_i);

    if (errors == 0) begin
      $display("indexed_priority_task_queue_core regression: pass");
    end else begin
      $display("indexed_priority_task_queue_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("indexed_priority_task_queue_core regression: fail");
    $finish;
  end

endmodule
